### hw/rtl/mis_pkg.sv
package mis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int VALUE_W   = 31;
    localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int INDEX_W   = $clog2(MAX_ITEMS);

    // Commands from the controller to the sorting chain
    typedef struct packed {
        logic               insert;
        logic               shift;
        logic [COUNT_W-1:0] count;
    } mis_cmd_t;

endpackage

### hw/rtl/mis_datapath.sv
module mis_datapath
    import mis_pkg::*;
(
    input  logic               aclk,
    input  mis_cmd_t           cmd,
    input  logic [VALUE_W-1:0] in_value,
    output logic [VALUE_W-1:0] head_value
);

    logic [VALUE_W-1:0] cell_reg  [MAX_ITEMS];
    logic [VALUE_W-1:0] cell_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] gt;

    // A cell is above the new item when it is empty or holds a larger value
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            gt[i] = (COUNT_W'(i) >= cmd.count) || (cell_reg[i] > in_value);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.insert) begin
                if (gt[i]) begin
                    if (i == 0) begin
                        cell_next[i] = in_value;
                    end else if (!gt[i-1]) begin
                        cell_next[i] = in_value;
                    end else begin
                        cell_next[i] = cell_reg[i-1];
                    end
                end
            end else if (cmd.shift) begin
                // advance toward the head; the tail becomes empty through count
                if (i < MAX_ITEMS - 1) begin
                    cell_next[i] = cell_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    assign head_value = cell_reg[0];

endmodule

### hw/rtl/mis_ctrl.sv
module mis_ctrl
    import mis_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  logic     s_last,
    output logic     m_valid,
    input  logic     m_ready,
    output logic     m_final_res,
    output logic     m_overflow,
    output mis_cmd_t cmd
);

    typedef enum logic [0:0] {
        COLLECT,
        EMIT
    } state_t;

    state_t             state_reg,   state_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               dropped_reg, dropped_next;
    logic               in_take;
    logic               out_take;
    logic               full;

    assign full     = (count_reg == COUNT_W'(MAX_ITEMS));
    assign in_take  = s_valid && (state_reg == COLLECT);
    assign out_take = m_ready && (state_reg == EMIT);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        unique case (state_reg)
            COLLECT: begin
                if (in_take) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    if (s_last) begin
                        state_next = EMIT;
                    end
                end
            end
            EMIT: begin
                if (out_take) begin
                    count_next = count_reg - COUNT_W'(1);
                    if (count_reg == COUNT_W'(1)) begin
                        dropped_next = 1'b0;
                        state_next   = COLLECT;
                    end
                end
            end
            default: state_next = COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign s_ready     = (state_reg == COLLECT);
    assign m_valid     = (state_reg == EMIT);
    assign m_final_res = (count_reg == COUNT_W'(1));
    assign m_overflow  = dropped_reg;

    assign cmd.insert = in_take && !full;
    assign cmd.shift  = out_take;
    assign cmd.count  = count_reg;

endmodule

### hw/rtl/merge_insertion_sorter.sv
// Sorting chain of MAX_ITEMS cells: items are taken one per cycle while a sequence
// is collected, each inserted in order, or dropped with the overflow flag set when
// the chain is full. The first result is offered the cycle after the item marked
// last is accepted; results then leave one per cycle while m_ready is high. No item
// is taken while a run drains. Synchronous active-low reset empties the chain and
// clears the overflow flag; cell contents are not reset.
module merge_insertion_sorter
    import mis_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_sorted_value,
    output logic               m_final_res,
    output logic               m_overflow
);

    mis_cmd_t cmd;

    mis_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_final_res (m_final_res),
        .m_overflow  (m_overflow),
        .cmd         (cmd)
    );

    mis_datapath u_datapath (
        .aclk       (aclk),
        .cmd        (cmd),
        .in_value   (s_value),
        .head_value (m_sorted_value)
    );

endmodule
